### hdl/sync_word_packet_deframer_core_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_WORD_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_WORD_PACKET_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge.
`define SWPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
// Next-cycle implication, sampled on the rising clock edge.
`define SWPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define SWPD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SWPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/swpd_pkg.sv
// Types and constants of the sync word packet deframer.
`default_nettype none

package swpd_pkg;

   localparam logic [7:0] SYNC_FIRST = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam logic [7:0] TYPE_RESET = 8'h01;

   // Byte positions inside the 8-byte frame.
   localparam logic [2:0] POS_SYNC1 = 3'd1;
   localparam logic [2:0] POS_TYPE = 3'd2;
   localparam logic [2:0] POS_ID_LO = 3'd3;
   localparam logic [2:0] POS_ID_HI = 3'd4;
   localparam logic [2:0] POS_LABEL = 3'd5;
   localparam logic [2:0] POS_CONF = 3'd6;
   localparam logic [2:0] POS_LAST = 3'd7;

   typedef struct packed {
      logic        frame_ok;
      logic [15:0] frame_number;
      logic [7:0]  label_code;
      logic [7:0]  confidence_code;
   } swpd_rsp_type;

endpackage

`default_nettype wire

### hdl/swpd_req_if.sv
// Input byte channel: valid/ready handshake with one received byte per beat.
`default_nettype none

interface swpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/swpd_rsp_if.sv
// Result channel: valid/ready handshake with one decoded frame per beat.
`default_nettype none

interface swpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [15:0] frame_number;
   logic [7:0]  label_code;
   logic [7:0]  confidence_code;

   modport source (output valid, output frame_ok, output frame_number,
                   output label_code, output confidence_code, input ready);
   modport sink (input valid, input frame_ok, input frame_number,
                 input label_code, input confidence_code, output ready);
endinterface

`default_nettype wire

### hdl/swpd_frame_fsm.sv
// Sync hunt state machine and frame field capture.
`default_nettype none
`include "sync_word_packet_deframer_core_assert.svh"

module swpd_frame_fsm
   import swpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic [7:0]   rx_byte,
   input  wire logic [7:0]   expected_type,
   output logic              done,
   output swpd_rsp_type      result
);

   typedef enum logic [1:0] {
      ST_HUNT = 2'd0,
      ST_SYNC = 2'd1,
      ST_BODY = 2'd2
   } state_type;

   state_type   state_ff;
   logic [2:0]  pos_ff;
   logic [7:0]  type_ff;
   logic [7:0]  id_lo_ff;
   logic [7:0]  id_hi_ff;
   logic [7:0]  label_ff;
   logic [7:0]  conf_ff;
   logic        in_body;
   logic        type_match;

   // The unused phase code behaves as body collection.
   assign in_body = (state_ff != ST_HUNT) && (state_ff != ST_SYNC);
   assign done = step && in_body && (pos_ff == POS_LAST);
   assign type_match = (type_ff == expected_type);

   always_comb begin
      result.frame_ok = type_match;
      result.frame_number = type_match ? {id_hi_ff, id_lo_ff} : 16'd0;
      result.label_code = type_match ? label_ff : 8'd0;
      result.confidence_code = type_match ? conf_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         pos_ff <= 3'd0;
      end else if (step) begin
         unique case (state_ff)
            ST_HUNT: begin
               if (rx_byte == SYNC_FIRST) begin
                  state_ff <= ST_SYNC;
                  pos_ff <= POS_SYNC1;
               end
            end
            ST_SYNC: begin
               if (rx_byte == SYNC_SECOND) begin
                  state_ff <= ST_BODY;
                  pos_ff <= POS_TYPE;
               end else if (rx_byte != SYNC_FIRST) begin
                  state_ff <= ST_HUNT;
                  pos_ff <= 3'd0;
               end
            end
            default: begin
               if (pos_ff == POS_LAST) begin
                  state_ff <= ST_HUNT;
                  pos_ff <= 3'd0;
               end else begin
                  pos_ff <= pos_ff + 3'd1;
               end
            end
         endcase
      end
   end

   // Field capture; sync bytes inside the body land here as plain data.
   always_ff @(posedge clock) begin
      if (step && in_body) begin
         unique case (pos_ff)
            POS_TYPE:  type_ff <= rx_byte;
            POS_ID_LO: id_lo_ff <= rx_byte;
            POS_ID_HI: id_hi_ff <= rx_byte;
            POS_LABEL: label_ff <= rx_byte;
            POS_CONF:  conf_ff <= rx_byte;
            default: begin
            end
         endcase
      end
   end

   `SWPD_ASSERT_NEXT(a_done_rehunt, clock, reset, done, state_ff == ST_HUNT && pos_ff == 3'd0)
   `SWPD_ASSERT_NOW(a_sync_pos, clock, reset, state_ff == ST_SYNC, pos_ff == POS_SYNC1)
   `SWPD_ASSERT_NOW(a_hunt_pos, clock, reset, state_ff == ST_HUNT, pos_ff == 3'd0)

endmodule

`default_nettype wire

### hdl/swpd_rsp_buf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none
`include "sync_word_packet_deframer_core_assert.svh"

module swpd_rsp_buf
   import swpd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_valid,
   output logic               up_ready,
   input  wire swpd_rsp_type  up_data,
   output logic               dn_valid,
   input  wire logic          dn_ready,
   output swpd_rsp_type       dn_data
);

   logic          main_vld_ff;
   logic          skid_vld_ff;
   swpd_rsp_type  main_ff;
   swpd_rsp_type  skid_ff;
   logic          pop;

   assign up_ready = !skid_vld_ff;
   assign dn_valid = main_vld_ff;
   assign dn_data = main_ff;
   assign pop = main_vld_ff && dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (up_valid) begin
         if (!main_vld_ff || pop) begin
            main_ff <= up_data;
            main_vld_ff <= 1'b1;
         end else begin
            skid_ff <= up_data;
            skid_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         main_vld_ff <= 1'b0;
      end
   end

   `SWPD_ASSERT_NOW(a_skid_implies_main, clock, reset, skid_vld_ff, main_vld_ff)
   `SWPD_ASSERT_NOW(a_no_push_when_full, clock, reset, up_valid, up_ready)
   `SWPD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_vld_ff && dn_ready, main_vld_ff && !skid_vld_ff)

endmodule

`default_nettype wire

### hdl/sync_word_packet_deframer_core.sv
// Top level of the sync word packet deframer.
// Takes one received byte per beat, hunts for the sync pair 0xAA 0x55 and
// emits one result beat per complete 8-byte frame (sync, sync, type, id low,
// id high, label, confidence, flags). The result is frame_ok plus the
// little-endian frame number, label and raw confidence; the fields read zero
// when the type byte differs from the csr-written expected type (reset 0x01).
// Throughput is one byte per cycle while the result buffer is not full: a byte
// goes from the input register through the single-pass parser, and a frame's
// result is registered in the result buffer once the parser has taken its last
// byte. The two-entry result buffer keeps input flowing while a result waits;
// input stalls only when both entries are full.
`default_nettype none

module sync_word_packet_deframer_core
   import swpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   swpd_req_if.sink         req_chan,
   swpd_rsp_if.source       rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic          in_vld_ff;
   logic [7:0]    in_byte_ff;
   logic [7:0]    expected_type_ff;
   logic          buf_ready;
   logic          step;
   logic          frame_done;
   swpd_rsp_type  frame_result;
   swpd_rsp_type  rsp_data;

   assign step = in_vld_ff && buf_ready;
   assign req_chan.ready = !in_vld_ff || buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         expected_type_ff <= TYPE_RESET;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (csr_wr_en) begin
            expected_type_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   swpd_frame_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rx_byte       (in_byte_ff),
      .expected_type (expected_type_ff),
      .done          (frame_done),
      .result        (frame_result)
   );

   swpd_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .up_valid (frame_done),
      .up_ready (buf_ready),
      .up_data  (frame_result),
      .dn_valid (rsp_chan.valid),
      .dn_ready (rsp_chan.ready),
      .dn_data  (rsp_data)
   );

   assign rsp_chan.frame_ok = rsp_data.frame_ok;
   assign rsp_chan.frame_number = rsp_data.frame_number;
   assign rsp_chan.label_code = rsp_data.label_code;
   assign rsp_chan.confidence_code = rsp_data.confidence_code;

endmodule

`default_nettype wire
